/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions on a clock with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in nearest crystal classifier");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in nearest crystal classifier");

`endif

/* hdl/nccl_pkg.sv */
// ----------------------------------------------------------------------------
// Nearest crystal classifier package
// Widths, command and status codes, and the beat carried along the cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nccl_pkg;

   localparam int NUM_CRYSTALS_DEF = 64;
   localparam int COORD_W          = 16;
   localparam int INDEX_W          = 6;
   localparam int SQ_W             = 32;
   localparam int DIST_W           = 33;
   localparam int INDEX_CMP_W      = 9;

   localparam logic signed [COORD_W-1:0] ONE_Q14     = 16'sd16384;
   localparam logic signed [COORD_W-1:0] NEG_ONE_Q14 = -16'sd16384;

   localparam logic CMD_CLASSIFY = 1'b0;
   localparam logic CMD_LOAD     = 1'b1;

   localparam logic STATUS_MATCH = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef struct packed {
      logic                      valid;
      logic                      oor;
      logic signed [COORD_W-1:0] ex;
      logic signed [COORD_W-1:0] ey;
      logic [DIST_W-1:0]         best_d;
   } beat_type;

endpackage

/* hdl/nccl_cell.sv */
// ----------------------------------------------------------------------------
// Nearest crystal classifier cell
// Holds one crystal centre and updates the running nearest match in two stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nccl_cell import nccl_pkg::*; #(
   parameter int NUM_CRYSTALS = NUM_CRYSTALS_DEF,
   parameter int CELL_INDEX   = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              load_en,
   input  logic signed [COORD_W-1:0]         load_x,
   input  logic signed [COORD_W-1:0]         load_y,
   input  beat_type                          beat_in,
   input  logic [$clog2(NUM_CRYSTALS)-1:0]   best_k_in,
   output beat_type                          beat_out,
   output logic [$clog2(NUM_CRYSTALS)-1:0]   best_k_out
);

   localparam int IDX_W = $clog2(NUM_CRYSTALS);
   localparam logic [IDX_W-1:0] OWN_INDEX = IDX_W'(CELL_INDEX);

   logic signed [COORD_W-1:0] cx_ff;
   logic signed [COORD_W-1:0] cy_ff;
   logic signed [COORD_W:0]   dx;
   logic signed [COORD_W:0]   dy;
   logic [COORD_W-1:0]        mx;
   logic [COORD_W-1:0]        my;

   logic                      a_valid_ff;
   beat_type                  a_beat_ff;
   logic [IDX_W-1:0]          a_best_k_ff;
   logic [SQ_W-1:0]           sqx_ff;
   logic [SQ_W-1:0]           sqy_ff;

   logic [DIST_W-1:0]         dist_sum;
   logic                      take;
   beat_type                  b_beat_in;
   logic [IDX_W-1:0]          b_best_k_in;
   logic                      b_valid_ff;
   beat_type                  b_beat_ff;
   logic [IDX_W-1:0]          b_best_k_ff;

   always_ff @(posedge clock) begin
      if (load_en) begin
         cx_ff <= load_x;
         cy_ff <= load_y;
      end
   end

   always_comb begin
      dx = {cx_ff[COORD_W-1], cx_ff} - {beat_in.ex[COORD_W-1], beat_in.ex};
      dy = {cy_ff[COORD_W-1], cy_ff} - {beat_in.ey[COORD_W-1], beat_in.ey};
      mx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
      my = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= beat_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_beat_ff   <= beat_in;
         a_best_k_ff <= best_k_in;
         sqx_ff      <= mx * mx;
         sqy_ff      <= my * my;
      end
   end

   always_comb begin
      dist_sum    = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      take        = (CELL_INDEX == 0) || (dist_sum < a_beat_ff.best_d);
      b_beat_in   = a_beat_ff;
      b_best_k_in = a_best_k_ff;
      if (take) begin
         b_beat_in.best_d = dist_sum;
         b_best_k_in      = OWN_INDEX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_beat_ff   <= b_beat_in;
         b_best_k_ff <= b_best_k_in;
      end
   end

   always_comb begin
      beat_out       = b_beat_ff;
      beat_out.valid = b_valid_ff;
      best_k_out     = b_best_k_ff;
   end

endmodule

/* hdl/nearest_crystal_classifier_core.sv */
// Pipeline: a classify beat passes two register stages per cell and then one output
// register before its result shows.
// Throughput: one classify beat per cycle through the pipelined cell chain while the
// response is not stalled; a load beat waits until no classify beat is left in the
// chain, then one per cycle. Reset clears all valid bits and the in-flight count;
// the crystal table is undefined until loaded.
// ----------------------------------------------------------------------------
// Nearest crystal classifier core
// Chain of cells, each holding one crystal centre, that finds the nearest entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_crystal_classifier_core import nccl_pkg::*; #(
   parameter int NUM_CRYSTALS = NUM_CRYSTALS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_command,
   input  logic signed [COORD_W-1:0] req_event_x,
   input  logic signed [COORD_W-1:0] req_event_y,
   input  logic [INDEX_W-1:0]        req_entry_index,
   input  logic signed [COORD_W-1:0] req_entry_x,
   input  logic signed [COORD_W-1:0] req_entry_y,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [INDEX_W-1:0]        rsp_crystal_index,
   output logic                      rsp_status
);

   localparam int IDX_W = $clog2(NUM_CRYSTALS);
   localparam int CNT_W = $clog2(2 * NUM_CRYSTALS + 1);

   beat_type               chain       [NUM_CRYSTALS+1];
   logic [IDX_W-1:0]       chain_k     [NUM_CRYSTALS+1];
   logic                   advance;
   logic                   classify_accept;
   logic                   load_accept;
   logic                   event_oor;
   logic                   leave;
   logic [CNT_W-1:0]       inflight_ff;
   logic [CNT_W-1:0]       inflight_in;
   logic [IDX_W+INDEX_W-1:0] k_wide;
   logic                   rsp_valid_ff;
   logic [INDEX_W-1:0]     rsp_index_ff;
   logic                   rsp_status_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = (req_command == CMD_LOAD) ? (inflight_ff == '0) : advance;

   assign classify_accept = req_valid && req_ready && (req_command == CMD_CLASSIFY);
   assign load_accept     = req_valid && req_ready && (req_command == CMD_LOAD);

   assign event_oor = (req_event_x > ONE_Q14) || (req_event_x < NEG_ONE_Q14) ||
                      (req_event_y > ONE_Q14) || (req_event_y < NEG_ONE_Q14);

   always_comb begin
      chain[0].valid  = classify_accept;
      chain[0].oor    = event_oor;
      chain[0].ex     = req_event_x;
      chain[0].ey     = req_event_y;
      chain[0].best_d = '0;
      chain_k[0]      = '0;
   end

   for (genvar k = 0; k < NUM_CRYSTALS; k++) begin : g_cell
      logic load_hit;

      assign load_hit = load_accept &&
                        (INDEX_CMP_W'(req_entry_index) == INDEX_CMP_W'(k));

      nccl_cell #(
         .NUM_CRYSTALS (NUM_CRYSTALS),
         .CELL_INDEX   (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .load_en    (load_hit),
         .load_x     (req_entry_x),
         .load_y     (req_entry_y),
         .beat_in    (chain[k]),
         .best_k_in  (chain_k[k]),
         .beat_out   (chain[k+1]),
         .best_k_out (chain_k[k+1])
      );
   end

   assign leave       = advance && chain[NUM_CRYSTALS].valid;
   assign inflight_in = inflight_ff + CNT_W'(classify_accept) - CNT_W'(leave);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   assign k_wide = {{INDEX_W{1'b0}}, chain_k[NUM_CRYSTALS]};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain[NUM_CRYSTALS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (leave) begin
         if (chain[NUM_CRYSTALS].oor) begin
            rsp_index_ff  <= '0;
            rsp_status_ff <= STATUS_RANGE;
         end else begin
            rsp_index_ff  <= k_wide[INDEX_W-1:0];
            rsp_status_ff <= STATUS_MATCH;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_crystal_index = rsp_index_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

/* hdl/nccl_checker.sv */
// ----------------------------------------------------------------------------
// Nearest crystal classifier checker
// Port-level assertions on the classifier core, attached by a bind statement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module nccl_checker import nccl_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_command,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [INDEX_W-1:0] rsp_crystal_index,
   input logic               rsp_status
);

   `ASSERT_NEXT_CYCLE(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_crystal_index) && $stable(rsp_status))
   `ASSERT_SAME_CYCLE(a_range_index_zero, clock, reset, rsp_valid && (rsp_status == STATUS_RANGE), rsp_crystal_index == '0)
   `ASSERT_SAME_CYCLE(a_no_rsp_after_reset, clock, reset, $past(reset), !rsp_valid)
   `ASSERT_SAME_CYCLE(a_stall_blocks_classify, clock, reset, rsp_valid && !rsp_ready, !(req_valid && req_ready && (req_command == CMD_CLASSIFY)))

endmodule

bind nearest_crystal_classifier_core nccl_checker u_nccl_checker (.*);
